[design/bfcr_pkg.sv]
`timescale 1ns / 1ps

package bfcr_pkg;

    localparam int READ_LEN_W = 7;

    localparam logic [2:0] OP_WRITE    = 3'd0;
    localparam logic [2:0] OP_PEEK     = 3'd1;
    localparam logic [2:0] OP_READ     = 3'd2;
    localparam logic [2:0] OP_ADVANCE  = 3'd3;
    localparam logic [2:0] OP_ROLLBACK = 3'd4;
    localparam logic [2:0] OP_COMMIT   = 3'd5;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  write_byte;
        logic [10:0] count;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        has_data;
        logic        last;
        logic        ok;
        logic        readable;
        logic [10:0] pending_bytes;
    } t_out_word;

    typedef struct packed {
        logic wr;
        logic rd;
        logic th_inc;
        logic th_adv;
        logic th_roll;
        logic ch_commit;
        logic ld_out;
        logic out_from_mem;
        logic out_last;
        logic out_ok;
    } t_cmd;

    typedef struct packed {
        logic                  full;
        logic                  adv_ok;
        logic                  pend_zero;
        logic [READ_LEN_W-1:0] read_len;
    } t_status;

endpackage

[design/byte_fifo_commit_rollback.sv]
`timescale 1ns / 1ps
// Byte queue with a committed head and a tentative head, so that reads can be
// taken back. Input words carry an opcode, a byte and a count on a valid/ready
// channel; result words leave on a second valid/ready channel from an output
// register, so a new word is taken in the cycle in which the previous result leaves.
// Write, advance, rollback, commit, a peek of an empty queue and a read of
// zero bytes produce one result, registered in the cycle after the word is accepted.
// A peek or a read that finds bytes issues a read of the byte store and
// gives its first result once the byte has passed the store's read register and
// the output register; a read then emits one byte per cycle while the receiver
// is ready, min(count, MAX_READ, pending) bytes in all, paced by the single
// registered read port of the byte store. The next input word is taken once
// the last byte of a read has been loaded into the output register. With the
// receiver always ready, single-result words are taken one per cycle.
// A stalled receiver holds the output register and with it the whole block;
// nothing is lost or repeated. Reset clears the tail, committed head and
// tentative head to zero and empties the output register; the byte store
// itself is not cleared, and no clearing pass is needed.
// Every result reports whether a byte lies at the tentative head and how many
// bytes lie between the tentative head and the tail.

module byte_fifo_commit_rollback #(
    parameter int DEPTH    = 1024,
    parameter int MAX_READ = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bfcr_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bfcr_pkg::t_out_word o_out_data
);

    import bfcr_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    bfcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_data.opcode),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    bfcr_dp #(
        .DEPTH   (DEPTH),
        .MAX_READ(MAX_READ)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_data (i_in_data),
        .i_cmd     (w_cmd),
        .o_status  (w_status),
        .o_out_data(o_out_data)
    );

    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.has_data) |-> o_out_data.ok)
        else $error("byte result without ok");

    a_burst_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last) |-> !o_in_ready)
        else $error("input taken inside a read burst");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (o_out_valid || !o_in_ready))
        else $error("accepted word produced no result");

    a_read_has_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.th_inc |-> (w_cmd.ld_out && w_cmd.out_from_mem))
        else $error("head moved without emitting a byte");

endmodule

[design/bfcr_ram.sv]
`timescale 1ns / 1ps

module bfcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/bfcr_dp.sv]
`timescale 1ns / 1ps

module bfcr_dp #(
    parameter int DEPTH    = 1024,
    parameter int MAX_READ = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bfcr_pkg::t_in_word i_in_data,
    input  bfcr_pkg::t_cmd     i_cmd,
    output bfcr_pkg::t_status  o_status,
    output bfcr_pkg::t_out_word o_out_data
);

    import bfcr_pkg::*;

    localparam int MW = $clog2(DEPTH);
    localparam int AW = MW + 1;
    localparam int CW = (AW > 11) ? AW : 11;
    localparam logic [AW:0]   SPAN_V  = (AW + 1)'(2 * DEPTH);
    localparam logic [AW-1:0] DEPTH_V = AW'(DEPTH);
    localparam logic [AW-1:0] LAST_V  = AW'(2 * DEPTH - 1);
    localparam logic [CW-1:0] MAXR_V  = CW'(MAX_READ);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_V) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_addn(input logic [AW-1:0] p,
                                              input logic [AW-1:0] c);
        logic [AW:0] s;
        s = {1'b0, p} + {1'b0, c};
        if (s >= SPAN_V) begin
            s = s - SPAN_V;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ptr_diff(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
        logic [AW:0] s;
        if (a >= b) begin
            s = {1'b0, a} - {1'b0, b};
        end else begin
            s = {1'b0, a} + SPAN_V - {1'b0, b};
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [MW-1:0] ptr_addr(input logic [AW-1:0] p);
        logic [AW-1:0] s;
        s = (p >= DEPTH_V) ? p - DEPTH_V : p;
        return s[MW-1:0];
    endfunction

    logic [AW-1:0] r_tail;
    logic [AW-1:0] r_ch;
    logic [AW-1:0] r_th;
    logic [AW-1:0] n_tail;
    logic [AW-1:0] n_ch;
    logic [AW-1:0] n_th;
    logic [AW-1:0] w_pend;
    logic [AW-1:0] w_pend_next;
    logic [CW-1:0] w_cnt;
    logic [CW-1:0] w_len_a;
    logic [CW-1:0] w_len_b;
    logic [7:0]    w_rdata;
    t_out_word     r_out;

    assign w_pend = ptr_diff(r_tail, r_th);
    assign w_cnt  = CW'(i_in_data.count);

    always_comb begin
        w_len_a = (w_cnt > MAXR_V) ? MAXR_V : w_cnt;
        w_len_b = (w_len_a > CW'(w_pend)) ? CW'(w_pend) : w_len_a;
    end

    assign o_status.full      = (ptr_diff(r_tail, r_ch) == DEPTH_V);
    assign o_status.adv_ok    = (w_cnt <= CW'(w_pend));
    assign o_status.pend_zero = (w_pend == '0);
    assign o_status.read_len  = READ_LEN_W'(w_len_b);

    always_comb begin
        n_tail = i_cmd.wr ? ptr_inc(r_tail) : r_tail;
        n_ch   = i_cmd.ch_commit ? r_th : r_ch;
        priority if (i_cmd.th_roll) begin
            n_th = r_ch;
        end else if (i_cmd.th_adv) begin
            n_th = ptr_addn(r_th, AW'(i_in_data.count));
        end else if (i_cmd.th_inc) begin
            n_th = ptr_inc(r_th);
        end else begin
            n_th = r_th;
        end
        w_pend_next = ptr_diff(n_tail, n_th);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail <= '0;
            r_ch   <= '0;
            r_th   <= '0;
        end else begin
            r_tail <= n_tail;
            r_ch   <= n_ch;
            r_th   <= n_th;
        end
    end

    bfcr_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr),
        .i_waddr(ptr_addr(r_tail)),
        .i_wdata(i_in_data.write_byte),
        .i_re   (i_cmd.rd),
        .i_raddr(ptr_addr(n_th)),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            r_out.data_byte     <= i_cmd.out_from_mem ? w_rdata : 8'd0;
            r_out.has_data      <= i_cmd.out_from_mem;
            r_out.last          <= i_cmd.out_last;
            r_out.ok            <= i_cmd.out_ok;
            r_out.readable      <= (w_pend_next != '0);
            r_out.pending_bytes <= 11'(w_pend_next);
        end
    end

    assign o_out_data = r_out;

endmodule

[design/bfcr_ctrl.sv]
`timescale 1ns / 1ps

module bfcr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [2:0]        i_opcode,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  bfcr_pkg::t_status i_status,
    output bfcr_pkg::t_cmd    o_cmd
);

    import bfcr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [READ_LEN_W-1:0] r_remain;
    logic [READ_LEN_W-1:0] n_remain;
    logic                  r_peek;
    logic                  n_peek;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  w_out_free;
    logic                  w_accept;
    t_cmd                  w_cmd;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        w_cmd    = '0;
        n_state  = r_state;
        n_remain = r_remain;
        n_peek   = r_peek;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_cmd.ld_out   = 1'b1;
                    w_cmd.out_last = 1'b1;
                    w_cmd.out_ok   = 1'b1;
                    unique case (i_opcode)
                        OP_WRITE: begin
                            w_cmd.wr     = !i_status.full;
                            w_cmd.out_ok = !i_status.full;
                        end
                        OP_PEEK: begin
                            if (!i_status.pend_zero) begin
                                w_cmd.ld_out = 1'b0;
                                w_cmd.rd     = 1'b1;
                                n_remain     = READ_LEN_W'(1);
                                n_peek       = 1'b1;
                                n_state      = S_READ;
                            end
                        end
                        OP_READ: begin
                            if (i_status.read_len != '0) begin
                                w_cmd.ld_out = 1'b0;
                                w_cmd.rd     = 1'b1;
                                n_remain     = i_status.read_len;
                                n_peek       = 1'b0;
                                n_state      = S_READ;
                            end
                        end
                        OP_ADVANCE: begin
                            w_cmd.th_adv = i_status.adv_ok;
                            w_cmd.out_ok = i_status.adv_ok;
                        end
                        OP_ROLLBACK: begin
                            w_cmd.th_roll = 1'b1;
                        end
                        OP_COMMIT: begin
                            w_cmd.ch_commit = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                if (w_out_free) begin
                    w_cmd.ld_out       = 1'b1;
                    w_cmd.out_from_mem = 1'b1;
                    w_cmd.out_ok       = 1'b1;
                    w_cmd.th_inc       = !r_peek;
                    w_cmd.out_last     = (r_remain == READ_LEN_W'(1));
                    n_remain           = r_remain - READ_LEN_W'(1);
                    if (r_remain == READ_LEN_W'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        w_cmd.rd = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = w_cmd.ld_out || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_remain    <= '0;
            r_peek      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_remain    <= n_remain;
            r_peek      <= n_peek;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule
